### rtl/core/hcls_pkg.sv
// Package: types, constants and scan-step functions of the content length scanner.
`timescale 1ns / 1ps

package hcls_pkg;

   // Field widths
   localparam int BYTE_BITS   = 8;
   localparam int CONFIG_BITS = 32;
   localparam int BODY_BITS   = 32;
   localparam int LENGTH_BITS = 32;
   localparam int ACC_WIDE    = LENGTH_BITS + 4;
   localparam int LIMIT_WIDE  = (LENGTH_BITS > CONFIG_BITS) ? LENGTH_BITS : CONFIG_BITS;

   localparam logic [CONFIG_BITS-1:0] MAX_BODY_RESET = CONFIG_BITS'(1048576);

   // Character codes
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_SP      = 8'h20;
   localparam logic [7:0] CHAR_HTAB    = 8'h09;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   localparam logic [2:0] PREFIX_LEN  = 3'd5;
   localparam logic [2:0] PREFIX_FAIL = 3'd7;
   localparam logic [3:0] NAME_LEN    = 4'd14;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_LEAD   = 3'd1,
      PH_NAME   = 3'd2,
      PH_TRAIL  = 3'd3,
      PH_VALUE  = 3'd4,
      PH_IGNORE = 3'd5
   } line_phase_type;

   typedef enum logic [1:0] {
      VP_LEAD   = 2'd0,
      VP_DIGITS = 2'd1,
      VP_TRAIL  = 2'd2
   } value_phase_type;

   typedef struct packed {
      logic                   pending_cr;
      logic                   on_first_line;
      logic [2:0]             prefix_position;
      line_phase_type         line_phase;
      logic [3:0]             name_position;
      logic                   name_matches;
      value_phase_type        value_phase;
      logic [LENGTH_BITS-1:0] length_accumulator;
      logic                   over_limit;
      logic                   length_found;
      logic                   error_seen;
      logic                   scan_stopped;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      pending_cr:         1'b0,
      on_first_line:      1'b1,
      prefix_position:    3'd0,
      line_phase:         PH_START,
      name_position:      4'd0,
      name_matches:       1'b1,
      value_phase:        VP_LEAD,
      length_accumulator: '0,
      over_limit:         1'b0,
      length_found:       1'b0,
      error_seen:         1'b0,
      scan_stopped:       1'b0
   };

   // One input transaction
   typedef struct packed {
      logic [BYTE_BITS-1:0] header_byte;
      logic                 last_byte;
   } req_item_type;

   // One result transaction
   typedef struct packed {
      logic                 length_ok;
      logic [BODY_BITS-1:0] body_length;
   } rsp_item_type;

   // Lowercase "content-length", one character per position
   function automatic logic [7:0] target_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = "c";
         4'd1:    ch = "o";
         4'd2:    ch = "n";
         4'd3:    ch = "t";
         4'd4:    ch = "e";
         4'd5:    ch = "n";
         4'd6:    ch = "t";
         4'd7:    ch = "-";
         4'd8:    ch = "l";
         4'd9:    ch = "e";
         4'd10:   ch = "n";
         4'd11:   ch = "g";
         4'd12:   ch = "t";
         4'd13:   ch = "h";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Status line prefix "HTTP/"
   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = "H";
         3'd1:    ch = "T";
         3'd2:    ch = "T";
         3'd3:    ch = "P";
         3'd4:    ch = "/";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Configured maximum clipped to the accumulator width
   function automatic logic [LENGTH_BITS-1:0] effective_limit(
      input logic [CONFIG_BITS-1:0] max_len);
      logic [LIMIT_WIDE-1:0] m;
      logic [LIMIT_WIDE-1:0] mask;
      m    = LIMIT_WIDE'(max_len);
      mask = LIMIT_WIDE'({LENGTH_BITS{1'b1}});
      return LENGTH_BITS'((m < mask) ? m : mask);
   endfunction

   // Feed one ordinary character of a line
   function automatic scan_state_type feed_char(
      input scan_state_type         s,
      input logic [7:0]             c,
      input logic [LENGTH_BITS-1:0] lim);
      scan_state_type      n;
      logic                blank;
      logic                digit;
      logic [7:0]          lc;
      logic [ACC_WIDE-1:0] wide_acc;
      logic [ACC_WIDE-1:0] prod;
      n        = s;
      blank    = (c == CHAR_SP) || (c == CHAR_HTAB);
      digit    = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      lc       = ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ? c + CASE_OFFSET : c;
      wide_acc = ACC_WIDE'(s.length_accumulator);
      // acc * 10 + digit; the low nibble of an ASCII digit is its value
      prod     = (wide_acc << 3) + (wide_acc << 1) + ACC_WIDE'(c[3:0]);

      if (!(s.error_seen || s.scan_stopped)) begin
         if (n.line_phase == PH_START) begin
            n.line_phase = PH_LEAD;
         end
         if (n.line_phase == PH_VALUE) begin
            // value text
            if (blank) begin
               if (n.value_phase == VP_DIGITS) begin
                  n.value_phase = VP_TRAIL;
               end
            end else if (digit && (n.value_phase != VP_TRAIL)) begin
               n.value_phase = VP_DIGITS;
               if (prod > ACC_WIDE'(lim)) begin
                  n.length_accumulator = lim;
                  n.over_limit         = 1'b1;
               end else begin
                  n.length_accumulator = LENGTH_BITS'(prod);
               end
            end else begin
               n.error_seen = 1'b1;
            end
         end else if (n.line_phase != PH_IGNORE) begin
            // name text
            if (c == CHAR_COLON) begin
               if (n.name_matches && (n.name_position == NAME_LEN)) begin
                  if (n.length_found) begin
                     n.error_seen = 1'b1;
                  end else begin
                     n.line_phase         = PH_VALUE;
                     n.value_phase        = VP_LEAD;
                     n.length_accumulator = '0;
                     n.over_limit         = 1'b0;
                  end
               end else begin
                  n.line_phase = PH_IGNORE;
               end
            end else if (blank) begin
               if (n.line_phase == PH_NAME) begin
                  n.line_phase = PH_TRAIL;
               end
            end else begin
               if (n.line_phase == PH_TRAIL) begin
                  n.name_matches = 1'b0;
               end
               n.line_phase = PH_NAME;
               if (n.name_matches && (n.name_position < NAME_LEN) &&
                   (lc == target_char(n.name_position))) begin
                  n.name_position = n.name_position + 4'd1;
               end else begin
                  n.name_matches = 1'b0;
               end
            end
            // status line prefix check
            if (!n.error_seen && n.on_first_line && (n.prefix_position < PREFIX_LEN)) begin
               if (c == prefix_char(n.prefix_position)) begin
                  n.prefix_position = n.prefix_position + 3'd1;
                  if (n.prefix_position == PREFIX_LEN) begin
                     n.line_phase = PH_IGNORE;
                  end
               end else begin
                  n.prefix_position = PREFIX_FAIL;
               end
            end
         end
      end
      return n;
   endfunction

   // Close the current line at CR LF or at the last byte
   function automatic scan_state_type end_line(input scan_state_type s);
      scan_state_type n;
      n = s;
      if (!(s.error_seen || s.scan_stopped)) begin
         if (s.line_phase == PH_START) begin
            n.scan_stopped = 1'b1;
         end else if ((s.line_phase == PH_LEAD) || (s.line_phase == PH_NAME) ||
                      (s.line_phase == PH_TRAIL)) begin
            n.error_seen = 1'b1;
         end else if ((s.line_phase == PH_VALUE) &&
                      ((s.value_phase == VP_LEAD) || s.over_limit)) begin
            n.error_seen = 1'b1;
         end else begin
            if (s.line_phase == PH_VALUE) begin
               n.length_found = 1'b1;
            end
            n.line_phase      = PH_START;
            n.name_position   = 4'd0;
            n.name_matches    = 1'b1;
            n.value_phase     = VP_LEAD;
            n.prefix_position = 3'd0;
            n.on_first_line   = 1'b0;
         end
      end
      return n;
   endfunction

endpackage

### rtl/core/hcls_if.sv
// Interfaces: request, response and register write channels of the scanner.
`timescale 1ns / 1ps

interface hcls_req_if import hcls_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] header_byte;
   logic                 last_byte;

   modport source (output valid, output header_byte, output last_byte, input ready);
   modport sink   (input valid, input header_byte, input last_byte, output ready);
endinterface

interface hcls_rsp_if import hcls_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic                 length_ok;
   logic [BODY_BITS-1:0] body_length;

   modport source (output valid, output length_ok, output body_length, input ready);
   modport sink   (input valid, input length_ok, input body_length, output ready);
endinterface

interface hcls_csr_if import hcls_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [CONFIG_BITS-1:0] max_body_length;

   modport source (output valid, output max_body_length, input ready);
   modport sink   (input valid, input max_body_length, output ready);
endinterface

### rtl/core/hcls_input_stage.sv
// Input register: captures one request transaction and holds it until the core takes it.
`timescale 1ns / 1ps

module hcls_input_stage import hcls_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  logic         take,
   input  req_item_type item_in,
   output logic         valid_out,
   output req_item_type item_out
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // occupancy: set on load, cleared when taken without refill
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign valid_out = valid_ff;
   assign item_out  = item_ff;

endmodule

### rtl/core/hcls_scan_core.sv
// Scan core: per-byte line and header state, updated once per taken byte.
`timescale 1ns / 1ps

module hcls_scan_core import hcls_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  req_item_type           item,
   input  logic [CONFIG_BITS-1:0] max_body_length,
   output rsp_item_type           result
);

   scan_state_type         state_ff;
   scan_state_type         state_in;
   scan_state_type         after_pending;
   scan_state_type         after_byte;
   scan_state_type         after_last;
   logic [LENGTH_BITS-1:0] limit;
   logic                   byte_used;
   logic                   ok;

   assign limit = effective_limit(max_body_length);

   // resolve a held CR, then the byte itself, then the end of region
   always_comb begin
      after_pending = state_ff;
      byte_used     = 1'b0;
      if (state_ff.pending_cr) begin
         after_pending.pending_cr = 1'b0;
         if (item.header_byte == CHAR_LF) begin
            after_pending = end_line(after_pending);
            byte_used     = 1'b1;
         end else begin
            after_pending = feed_char(after_pending, CHAR_CR, limit);
         end
      end

      after_byte = after_pending;
      if (!byte_used) begin
         if ((item.header_byte == CHAR_CR) && !item.last_byte) begin
            after_byte.pending_cr = 1'b1;
         end else begin
            after_byte = feed_char(after_pending, item.header_byte, limit);
         end
      end

      after_last = end_line(after_byte);
   end

   // verdict on the last byte
   assign ok                 = !after_last.error_seen && after_last.length_found;
   assign result.length_ok   = ok;
   assign result.body_length = ok ? BODY_BITS'(after_last.length_accumulator) : '0;

   always_comb begin
      state_in = state_ff;
      if (take) begin
         state_in = item.last_byte ? SCAN_RESET : after_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/hcls_result_reg.sv
// Result register: holds one response transaction until the sink takes it.
`timescale 1ns / 1ps

module hcls_result_reg import hcls_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type item_in,
   input  logic         sink_ready,
   output logic         valid_out,
   output logic         free,
   output rsp_item_type item_out
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign free = !valid_ff || sink_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (sink_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign valid_out = valid_ff;
   assign item_out  = item_ff;

endmodule

### rtl/core/http_content_length_scanner_unit.sv
// Top level: content length scanner with input register, scan core and result register.
//
//   channel   modport  payload                        role
//   req_chan  sink     header_byte[7:0], last_byte    header bytes, one per transaction
//   rsp_chan  source   length_ok, body_length[31:0]   one verdict per region
//   csr_chan  sink     max_body_length[31:0]          limit register write
//
// One byte per cycle sustained while no last byte waits for a full result register.
// The scan state updates in one pass from the input register to the result register.
// A response appears only for a byte with last_byte set; other bytes give none.
// Reset clears the scan state and sets max_body_length to 1048576.
// A waiting response holds the next last byte in the input register, and the request
// channel then stalls behind it until the response is taken.
`timescale 1ns / 1ps

module http_content_length_scanner_unit import hcls_pkg::*; (
   input logic       clock,
   input logic       reset,
   hcls_req_if.sink  req_chan,
   hcls_rsp_if.source rsp_chan,
   hcls_csr_if.sink  csr_chan
);

   logic                   stage_valid;
   req_item_type           stage_item;
   req_item_type           req_item;
   logic                   take;
   logic                   out_free;
   rsp_item_type           scan_result;
   rsp_item_type           rsp_item;
   logic [CONFIG_BITS-1:0] max_len_ff;

   // limit register, always writable
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_BODY_RESET;
      end else if (csr_chan.valid) begin
         max_len_ff <= csr_chan.max_body_length;
      end
   end

   // byte leaves the input register unless it needs a full result slot
   assign take           = stage_valid && (!stage_item.last_byte || out_free);
   assign req_chan.ready = !stage_valid || take;

   assign req_item.header_byte = req_chan.header_byte;
   assign req_item.last_byte   = req_chan.last_byte;

   hcls_input_stage u_input_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (req_chan.valid && req_chan.ready),
      .take      (take),
      .item_in   (req_item),
      .valid_out (stage_valid),
      .item_out  (stage_item)
   );

   hcls_scan_core u_scan_core (
      .clock           (clock),
      .reset           (reset),
      .take            (take),
      .item            (stage_item),
      .max_body_length (max_len_ff),
      .result          (scan_result)
   );

   hcls_result_reg u_result_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (take && stage_item.last_byte),
      .item_in    (scan_result),
      .sink_ready (rsp_chan.ready),
      .valid_out  (rsp_chan.valid),
      .free       (out_free),
      .item_out   (rsp_item)
   );

   assign rsp_chan.length_ok   = rsp_item.length_ok;
   assign rsp_chan.body_length = rsp_item.body_length;

endmodule

### test/tb_top.sv
// Testbench: feeds header regions byte by byte into the scanner and checks every verdict.
`timescale 1ns / 1ps

module tb_top;
   import hcls_pkg::*;

   localparam int          PHASE_BYTES = 220;
   localparam int unsigned CYCLE_LIMIT = 200000;

   // Name and prefix the scanner looks for, first character in the top byte
   localparam logic [8*14-1:0] FIELD_TEXT  = "content-length";
   localparam logic [8*5-1:0]  STATUS_TEXT = "HTTP/";

   logic clock = 1'b0;
   logic reset;

   hcls_req_if req_bus ();
   hcls_rsp_if rsp_bus ();
   hcls_csr_if csr_bus ();

   http_content_length_scanner_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bytes waiting for the driver, verdicts waiting for the block
   req_item_type pending_bytes[$];
   rsp_item_type expected_verdicts[$];
   int unsigned  queued_bytes;
   int unsigned  mismatch_count;
   int unsigned  verdict_count;
   int unsigned  cycle_count;

   // Scan state of the predictor
   logic [CONFIG_BITS-1:0] limit_copy;
   logic                   cr_held;
   logic                   top_line;
   logic [2:0]             status_cnt;
   line_phase_type         line_state;
   logic [3:0]             name_cnt;
   logic                   name_hit;
   value_phase_type        val_state;
   logic [LENGTH_BITS-1:0] acc;
   logic                   saturated;
   logic                   length_seen;
   logic                   failed;
   logic                   halted;

   //--------------------------------------------------------------------------
   // Predictor
   //--------------------------------------------------------------------------
   function automatic void clear_scan();
      cr_held     = 1'b0;
      top_line    = 1'b1;
      status_cnt  = '0;
      line_state  = PH_START;
      name_cnt    = '0;
      name_hit    = 1'b1;
      val_state   = VP_LEAD;
      acc         = '0;
      saturated   = 1'b0;
      length_seen = 1'b0;
      failed      = 1'b0;
      halted      = 1'b0;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SP) || (c == CHAR_HTAB);
   endfunction

   // One ordinary character of the current line
   function automatic void scan_char(input logic [7:0] c);
      logic [63:0] cap;
      logic [63:0] grown;
      logic [7:0]  lc;
      if (failed || halted) return;
      if (line_state == PH_START) line_state = PH_LEAD;
      if (line_state == PH_IGNORE) return;
      // value text
      if (line_state == PH_VALUE) begin
         cap = 64'(limit_copy);
         if (LENGTH_BITS < 64 && cap > ((64'd1 << LENGTH_BITS) - 64'd1)) begin
            cap = (64'd1 << LENGTH_BITS) - 64'd1;
         end
         if (is_blank(c)) begin
            if (val_state == VP_DIGITS) val_state = VP_TRAIL;
         end else if (c >= CHAR_ZERO && c <= CHAR_NINE && val_state != VP_TRAIL) begin
            grown     = 64'(acc) * 64'd10 + 64'(c - CHAR_ZERO);
            val_state = VP_DIGITS;
            if (grown > cap) begin
               grown     = cap;
               saturated = 1'b1;
            end
            acc = LENGTH_BITS'(grown);
         end else begin
            failed = 1'b1;
         end
         return;
      end
      // name text
      lc = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
      if (c == CHAR_COLON) begin
         if (name_hit && name_cnt == NAME_LEN) begin
            if (length_seen) begin
               failed = 1'b1;
               return;
            end
            line_state = PH_VALUE;
            val_state  = VP_LEAD;
            acc        = '0;
            saturated  = 1'b0;
         end else begin
            line_state = PH_IGNORE;
         end
      end else if (is_blank(c)) begin
         if (line_state == PH_NAME) line_state = PH_TRAIL;
      end else begin
         if (line_state == PH_TRAIL) name_hit = 1'b0;
         line_state = PH_NAME;
         if (name_hit && name_cnt < NAME_LEN &&
             lc == FIELD_TEXT[8*(int'(NAME_LEN) - 1 - int'(name_cnt)) +: 8]) begin
            name_cnt = name_cnt + 4'd1;
         end else begin
            name_hit = 1'b0;
         end
      end
      // status line detection on the first line
      if (top_line && status_cnt < PREFIX_LEN) begin
         if (c == STATUS_TEXT[8*(int'(PREFIX_LEN) - 1 - int'(status_cnt)) +: 8]) begin
            status_cnt = status_cnt + 3'd1;
            if (status_cnt == PREFIX_LEN) line_state = PH_IGNORE;
         end else begin
            status_cnt = PREFIX_FAIL;
         end
      end
   endfunction

   // Line end at CR LF or at the last byte
   function automatic void close_line();
      if (failed || halted) return;
      if (line_state == PH_START) begin
         halted = 1'b1;
         return;
      end
      if (line_state == PH_LEAD || line_state == PH_NAME || line_state == PH_TRAIL) begin
         failed = 1'b1;
         return;
      end
      if (line_state == PH_VALUE) begin
         if (val_state == VP_LEAD || saturated) begin
            failed = 1'b1;
            return;
         end
         length_seen = 1'b1;
      end
      line_state = PH_START;
      name_cnt   = '0;
      name_hit   = 1'b1;
      val_state  = VP_LEAD;
      status_cnt = '0;
      top_line   = 1'b0;
   endfunction

   // Advance the scan by one accepted byte; queue the verdict on the last one
   function automatic void track_header_byte(input logic [7:0] c, input logic last);
      rsp_item_type verdict;
      logic         take;
      logic         ok;
      take = 1'b1;
      if (cr_held) begin
         cr_held = 1'b0;
         if (c == CHAR_LF) begin
            close_line();
            take = 1'b0;
         end else begin
            scan_char(CHAR_CR);
         end
      end
      if (take) begin
         if (c == CHAR_CR && !last) cr_held = 1'b1;
         else scan_char(c);
      end
      if (last) begin
         close_line();
         ok                  = !failed && length_seen;
         verdict.length_ok   = ok;
         verdict.body_length = ok ? BODY_BITS'(acc) : '0;
         expected_verdicts.push_back(verdict);
         clear_scan();
      end
   endfunction

   //--------------------------------------------------------------------------
   // Region builder
   //--------------------------------------------------------------------------
   function automatic void add_byte(input logic [7:0] b);
      req_item_type item;
      item.header_byte = b;
      item.last_byte   = 1'b0;
      pending_bytes.push_back(item);
      queued_bytes++;
   endfunction

   function automatic void add_text(input string s);
      for (int k = 0; k < s.len(); k++) add_byte(s[k]);
   endfunction

   function automatic void add_blanks(input int unsigned most);
      repeat ($urandom_range(most)) add_byte($urandom_range(1) ? CHAR_SP : CHAR_HTAB);
   endfunction

   // Arbitrary bytes except the line terminator characters
   function automatic void add_junk(input int unsigned count);
      logic [7:0] b;
      repeat (count) begin
         b = 8'($urandom_range(1, 255));
         if (b == CHAR_CR || b == CHAR_LF) b = "~";
         add_byte(b);
      end
   endfunction

   function automatic void close_region();
      req_item_type tail;
      tail           = pending_bytes.pop_back();
      tail.last_byte = 1'b1;
      pending_bytes.push_back(tail);
   endfunction

   function automatic string number_text();
      logic [63:0] v;
      string       s;
      case ($urandom_range(7))
         0:       v = 64'($urandom_range(9));
         1:       v = 64'($urandom_range(99999));
         2:       v = 64'(limit_copy);
         3:       v = 64'(limit_copy) + 64'd1;
         4:       v = (limit_copy == '0) ? 64'd0 : 64'(limit_copy) - 64'd1;
         5:       v = 64'($urandom());
         6:       v = {$urandom(), $urandom()};
         default: v = 64'($urandom_range(2000));
      endcase
      s = $sformatf("%0d", v);
      if ($urandom_range(7) == 0) s = {"00", s};
      return s;
   endfunction

   // Content-length name with random case, blanks and the odd near miss
   function automatic void add_length_name();
      string       nm;
      int unsigned spot;
      nm = "content-length";
      for (int k = 0; k < nm.len(); k++) begin
         if ($urandom_range(3) == 0 && nm[k] >= "a" && nm[k] <= "z") nm[k] = nm[k] - CASE_OFFSET;
      end
      spot = $urandom_range(13);
      case ($urandom_range(15))
         0:       nm = nm.substr(0, 12);
         1:       nm = {nm, "s"};
         2:       nm = {nm.substr(0, 6), " ", nm.substr(7, 13)};
         3:       nm[spot] = "x";
         default: ;
      endcase
      add_blanks(2);
      add_text(nm);
      add_blanks(2);
   endfunction

   function automatic void add_length_value();
      string num;
      num = number_text();
      add_blanks(2);
      case ($urandom_range(19))
         0:       ;
         1: begin
            add_text(num);
            add_byte(CHAR_SP);
            add_text("5");
         end
         2: begin
            add_text(num);
            add_byte(CHAR_CR);
            add_text("0");
         end
         3: begin
            add_text(num);
            add_text("k");
         end
         default: add_text(num);
      endcase
      add_blanks(2);
   endfunction

   function automatic void add_length_line();
      add_length_name();
      add_byte(CHAR_COLON);
      add_length_value();
   endfunction

   function automatic void add_other_line();
      case ($urandom_range(9))
         0: add_text("Server nocolon");
         1: begin
            add_byte(CHAR_COLON);
            add_junk($urandom_range(4));
         end
         2: add_text(" Content-Lengths:12");
         3: add_text("Content-Len: 5");
         default: begin
            case ($urandom_range(3))
               0:       add_text("Host");
               1:       add_text("Server");
               2:       add_text("Content-Type");
               default: add_text("X-Trace");
            endcase
            add_blanks(1);
            add_byte(CHAR_COLON);
            add_blanks(2);
            add_junk($urandom_range(6));
         end
      endcase
   endfunction

   function automatic void add_status_line();
      case ($urandom_range(6))
         0, 1, 2: add_text("HTTP/1.1 200 OK");
         3:       add_text("HTTP/1.0 204 No Content");
         4:       add_text("HTTP 200 OK");
         5:       add_text("http/1.1 200: OK");
         default: add_text("HTTP/");
      endcase
   endfunction

   // One header region: mostly well formed, sometimes plain noise
   function automatic void queue_region();
      int unsigned n_lines;
      int unsigned length_at;
      int unsigned ending;
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(3))
               0:       add_byte(CHAR_CR);
               1:       add_byte(CHAR_LF);
               default: add_byte(8'($urandom_range(255)));
            endcase
         end
      end else begin
         if ($urandom_range(4) < 2) begin
            add_status_line();
            add_text("\r\n");
         end
         n_lines   = $urandom_range(2);
         length_at = $urandom_range(n_lines + 1);
         ending    = $urandom_range(9);
         for (int k = 0; k <= n_lines; k++) begin
            if (k == length_at) add_length_line();
            else add_other_line();
            if (k < n_lines || ending != 9) add_text("\r\n");
         end
         // duplicate header
         if (ending != 9 && $urandom_range(9) == 0) begin
            add_length_line();
            add_text("\r\n");
         end
         if (ending < 7) add_text("\r\n");
         if (ending == 6) add_junk($urandom_range(1, 6));
         if (ending == 8 || (ending == 9 && $urandom_range(1) == 1)) add_byte(CHAR_CR);
      end
      close_region();
   endfunction

   function automatic void queue_regions(input int unsigned count);
      int unsigned start;
      start = queued_bytes;
      while (queued_bytes - start < count) queue_region();
   endfunction

   function automatic int unsigned pick_idle_max();
      case ($urandom_range(2))
         0:       return 0;
         1:       return 3;
         default: return 13;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   //--------------------------------------------------------------------------
   // Request driver
   //--------------------------------------------------------------------------
   logic         req_hold;
   int unsigned  req_gap;
   int unsigned  req_gap_max;
   req_item_type req_next;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_hold    = 1'b0;
         req_gap     = 0;
         req_gap_max = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            track_header_byte(req_bus.header_byte, req_bus.last_byte);
            req_hold = 1'b0;
            if ($urandom_range(63) == 0) req_gap_max = pick_idle_max();
            req_gap = $urandom_range(req_gap_max);
         end
         if (!req_hold) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_next = pending_bytes.pop_front();
               req_bus.header_byte <= req_next.header_byte;
               req_bus.last_byte   <= req_next.last_byte;
               req_bus.valid       <= 1'b1;
               req_hold = 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   //--------------------------------------------------------------------------
   // Response monitor
   //--------------------------------------------------------------------------
   int unsigned  rsp_stall;
   int unsigned  rsp_stall_max;
   rsp_item_type rsp_want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     = 0;
         rsp_stall_max = 13;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("verdict transaction with none expected");
            end else begin
               rsp_want = expected_verdicts.pop_front();
               if (rsp_bus.length_ok !== rsp_want.length_ok) begin
                  report_mismatch($sformatf("verdict %0d: length_ok %0b, expected %0b",
                                            verdict_count, rsp_bus.length_ok,
                                            rsp_want.length_ok));
               end
               if (rsp_bus.body_length !== rsp_want.body_length) begin
                  report_mismatch($sformatf("verdict %0d: body_length %0d, expected %0d",
                                            verdict_count, rsp_bus.body_length,
                                            rsp_want.body_length));
               end
            end
            verdict_count++;
            if ($urandom_range(7) == 0) rsp_stall_max = pick_idle_max();
            rsp_stall = $urandom_range(rsp_stall_max);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** http_content_length_scanner_unit: FAILED **");
         $finish;
      end
   end

   //--------------------------------------------------------------------------
   // Sequence
   //--------------------------------------------------------------------------
   // Block idle: every byte sent, every verdict back, pipeline flushed
   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_bus.valid || expected_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_length(input logic [CONFIG_BITS-1:0] value);
      @(posedge clock);
      csr_bus.max_body_length <= value;
      csr_bus.valid           <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      limit_copy = value;
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.header_byte     = '0;
      req_bus.last_byte       = 1'b0;
      rsp_bus.ready           = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.max_body_length = '0;
      limit_copy              = MAX_BODY_RESET;
      clear_scan();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: byte extremes, lone CR at the end, empty region, minimal header
      add_byte(8'h00);
      close_region();
      add_byte(8'hFF);
      close_region();
      add_byte(CHAR_CR);
      close_region();
      add_text("\r\n");
      close_region();
      add_text("content-length:0");
      close_region();
      queue_regions(PHASE_BYTES);
      wait_drained();

      // Random regions under a sweep of limits, the extremes among them
      for (int p = 0; p < 7; p++) begin
         case (p)
            0:       write_max_length('0);
            1:       write_max_length('1);
            2:       write_max_length(CONFIG_BITS'($urandom_range(1, 999)));
            3:       write_max_length(CONFIG_BITS'($urandom()));
            4:       write_max_length(CONFIG_BITS'(9));
            5:       write_max_length(CONFIG_BITS'($urandom_range(1000, 10000000)));
            default: write_max_length(MAX_BODY_RESET);
         endcase
         queue_regions(PHASE_BYTES);
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("** http_content_length_scanner_unit: PASSED **");
      end else begin
         $display("** http_content_length_scanner_unit: FAILED **");
      end
      $finish;
   end

endmodule
